// ----- src/crmr_pkg.sv -----
// Package with the item types, codes and controller types of the client registry router.
package crmr_pkg;

  localparam int unsigned READER_SLOTS_DEF = 10;
  localparam int unsigned SENDER_SLOTS_DEF = 10;

  localparam logic [10:0] READER_ID_MIN = 11'd1;
  localparam logic [10:0] READER_ID_MAX = 11'd999;
  localparam logic [10:0] SENDER_ID_MIN = 11'd1001;
  localparam logic [10:0] SENDER_ID_MAX = 11'd1998;
  localparam logic signed [11:0] DEST_LIMIT = 12'sd1000;
  localparam logic signed [11:0] DEST_BCAST = 12'sd0;
  localparam logic signed [11:0] DEST_BYE   = -12'sd1;

  localparam logic [1:0] CMD_JOIN  = 2'd0;
  localparam logic [1:0] CMD_LEAVE = 2'd1;
  localparam logic [1:0] CMD_ROUTE = 2'd2;

  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_DELIVER = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_DUPLICATE    = 4'd1;
  localparam logic [3:0] ST_FULL         = 4'd2;
  localparam logic [3:0] ST_BAD_ID       = 4'd3;
  localparam logic [3:0] ST_NOT_REG      = 4'd4;
  localparam logic [3:0] ST_DEST_NOT_RD  = 4'd5;
  localparam logic [3:0] ST_SENDER_UNK   = 4'd6;
  localparam logic [3:0] ST_DEST_MISSING = 4'd7;
  localparam logic [3:0] ST_BAD_DEST     = 4'd8;

  localparam logic [1:0] RT_JOIN  = 2'd0;
  localparam logic [1:0] RT_BYE   = 2'd1;
  localparam logic [1:0] RT_ROUTE = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [10:0]        orig_id;
    logic signed [11:0] dest_id;
    logic [9:0]         conn;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         status;
    logic [9:0]         conn_out;
    logic [1:0]         reply_type;
    logic signed [11:0] orig_out;
    logic signed [11:0] dest_out;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_BCAST
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic bstep;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bcast;
    logic bdone;
  } dp_stat_t;

endpackage

// ----- src/crmr_ctrl.sv -----
// Controller state machine that sequences accept, table evaluation and broadcast steps.
module crmr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output crmr_pkg::ctrl_cmd_t  cmd,
  input  crmr_pkg::dp_stat_t   stat
);

  crmr_pkg::fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crmr_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      crmr_pkg::FSM_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = crmr_pkg::FSM_EXEC;
        end
      end
      crmr_pkg::FSM_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.bcast ? crmr_pkg::FSM_BCAST : crmr_pkg::FSM_IDLE;
      end
      crmr_pkg::FSM_BCAST: begin
        cmd.bstep = 1'b1;
        if (stat.bdone) begin
          state_nxt = crmr_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = crmr_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

// ----- src/crmr_dp.sv -----
// Datapath with the client table, the parallel slot compares and the result register.
module crmr_dp #(
  parameter int unsigned READER_SLOTS = crmr_pkg::READER_SLOTS_DEF,
  parameter int unsigned SENDER_SLOTS = crmr_pkg::SENDER_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crmr_pkg::in_item_t   in_item,
  input  crmr_pkg::ctrl_cmd_t  cmd,
  output crmr_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  output crmr_pkg::out_item_t  out_item
);

  localparam int unsigned TOTAL = READER_SLOTS + SENDER_SLOTS;
  localparam logic [TOTAL-1:0] RD_MASK = TOTAL'((65'd1 << READER_SLOTS) - 65'd1);
  localparam logic [TOTAL-1:0] SD_MASK = ~RD_MASK;

  function automatic logic [TOTAL-1:0] lowest_all(input logic [TOTAL-1:0] v);
    return v & (~v + TOTAL'(1));
  endfunction

  function automatic logic [READER_SLOTS-1:0] lowest_rd(input logic [READER_SLOTS-1:0] v);
    return v & (~v + READER_SLOTS'(1));
  endfunction

  crmr_pkg::in_item_t  in_r;
  crmr_pkg::out_item_t out_item_r;
  logic                out_valid_r;
  logic [TOTAL-1:0]    valid_r;
  logic [10:0]         client_r [TOTAL];
  logic [9:0]          handle_r [TOTAL];
  logic [READER_SLOTS-1:0] pend_r;

  logic                is_rd, is_sd;
  logic [TOTAL-1:0]    id_hit, lv_hit, dm_hit;
  logic [TOTAL-1:0]    free_oh, lv_oh, dm_oh, sel_oh;
  logic [TOTAL-1:0]    set_oh, clr_oh;
  logic [READER_SLOTS-1:0] pend_oh, pend_rest;
  logic [9:0]          sel_handle;
  logic                bcast_go;
  crmr_pkg::out_item_t xres, bres;

  assign is_rd = in_r.orig_id inside {[crmr_pkg::READER_ID_MIN:crmr_pkg::READER_ID_MAX]};
  assign is_sd = in_r.orig_id inside {[crmr_pkg::SENDER_ID_MIN:crmr_pkg::SENDER_ID_MAX]};

  always_comb begin
    for (int i = 0; i < TOTAL; i++) begin
      id_hit[i] = valid_r[i] && (client_r[i] == in_r.orig_id);
      lv_hit[i] = id_hit[i] && (handle_r[i] == in_r.conn);
      dm_hit[i] = valid_r[i] && (client_r[i] == in_r.dest_id[10:0]);
    end
  end

  assign free_oh   = lowest_all(~valid_r & (is_rd ? RD_MASK : SD_MASK));
  assign lv_oh     = lowest_all(is_rd ? (lv_hit & RD_MASK) : (id_hit & SD_MASK));
  assign dm_oh     = lowest_all(dm_hit & RD_MASK);
  assign pend_oh   = lowest_rd(pend_r);
  assign pend_rest = pend_r & ~pend_oh;
  assign sel_oh    = cmd.bstep ? TOTAL'(pend_oh) : dm_oh;

  always_comb begin
    sel_handle = '0;
    for (int i = 0; i < TOTAL; i++) begin
      if (sel_oh[i]) begin
        sel_handle = sel_handle | handle_r[i];
      end
    end
  end

  always_comb begin
    xres     = '0;
    xres.kind = crmr_pkg::KIND_NONE;
    xres.status = crmr_pkg::ST_OK;
    xres.last = 1'b1;
    set_oh   = '0;
    clr_oh   = '0;
    bcast_go = 1'b0;
    case (in_r.cmd)
      crmr_pkg::CMD_JOIN: begin
        xres.conn_out   = in_r.conn;
        xres.reply_type = crmr_pkg::RT_JOIN;
        if (|id_hit) begin
          xres.status = crmr_pkg::ST_DUPLICATE;
        end else if (!is_rd && !is_sd) begin
          xres.status = crmr_pkg::ST_BAD_ID;
        end else if (free_oh == '0) begin
          xres.status = crmr_pkg::ST_FULL;
        end else begin
          set_oh        = free_oh;
          xres.kind     = crmr_pkg::KIND_REPLY;
          xres.orig_out = in_r.dest_id;
          xres.dest_out = {1'b0, in_r.orig_id};
        end
      end
      crmr_pkg::CMD_LEAVE: begin
        xres.kind       = crmr_pkg::KIND_REPLY;
        xres.conn_out   = in_r.conn;
        xres.reply_type = crmr_pkg::RT_BYE;
        xres.dest_out   = crmr_pkg::DEST_BYE;
        xres.status     = crmr_pkg::ST_BAD_ID;
        if (is_rd || is_sd) begin
          if (lv_oh != '0) begin
            clr_oh      = lv_oh;
            xres.status = crmr_pkg::ST_OK;
          end else begin
            xres.status = crmr_pkg::ST_NOT_REG;
          end
        end
      end
      crmr_pkg::CMD_ROUTE: begin
        xres.conn_out   = in_r.conn;
        xres.reply_type = crmr_pkg::RT_ROUTE;
        xres.orig_out   = {1'b0, in_r.orig_id};
        xres.dest_out   = in_r.dest_id;
        if (in_r.dest_id > crmr_pkg::DEST_LIMIT || in_r.dest_id[11]) begin
          xres.status = crmr_pkg::ST_DEST_NOT_RD;
        end else if ((id_hit & SD_MASK) == '0) begin
          xres.status = crmr_pkg::ST_SENDER_UNK;
        end else if (in_r.dest_id == crmr_pkg::DEST_BCAST) begin
          xres.dest_out = crmr_pkg::DEST_BCAST;
          bcast_go      = (valid_r & RD_MASK) != '0;
        end else if (in_r.dest_id == crmr_pkg::DEST_LIMIT) begin
          xres.status = crmr_pkg::ST_BAD_DEST;
        end else if (dm_oh == '0) begin
          xres.status = crmr_pkg::ST_DEST_MISSING;
        end else begin
          xres.kind     = crmr_pkg::KIND_DELIVER;
          xres.conn_out = sel_handle;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    bres            = '0;
    bres.kind       = crmr_pkg::KIND_DELIVER;
    bres.status     = crmr_pkg::ST_OK;
    bres.conn_out   = sel_handle;
    bres.reply_type = crmr_pkg::RT_ROUTE;
    bres.orig_out   = {1'b0, in_r.orig_id};
    bres.dest_out   = crmr_pkg::DEST_BCAST;
    bres.last       = (pend_rest == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.exec && !bcast_go) || cmd.bstep;
      if (cmd.exec) begin
        valid_r <= (valid_r & ~clr_oh) | set_oh;
        if (bcast_go) begin
          pend_r <= valid_r[READER_SLOTS-1:0];
        end
      end else if (cmd.bstep) begin
        pend_r <= pend_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
    if (cmd.exec || cmd.bstep) begin
      out_item_r <= cmd.bstep ? bres : xres;
    end
    for (int i = 0; i < TOTAL; i++) begin
      if (cmd.exec && set_oh[i]) begin
        client_r[i] <= in_r.orig_id;
        handle_r[i] <= in_r.conn;
      end
    end
  end

  assign stat.bcast = bcast_go;
  assign stat.bdone = (pend_rest == '0);
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

endmodule

// ----- src/client_registry_message_router.sv -----
// Top level of the client registry and message router.
// An item is accepted when start is high and busy is low. Unless it is a broadcast route,
// its single result strobes on out_valid once the item has been registered and all table
// slots have been compared in parallel and the result register loaded. A broadcast
// route produces one result per registered reader on consecutive cycles, in slot order,
// and the block stays busy through its broadcast steps. Results cannot be held off
// and must be taken in the cycle they appear; the item's final result carries last.
module client_registry_message_router #(
  parameter int unsigned READER_SLOTS = crmr_pkg::READER_SLOTS_DEF,
  parameter int unsigned SENDER_SLOTS = crmr_pkg::SENDER_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  crmr_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output crmr_pkg::out_item_t  out_item
);

  crmr_pkg::ctrl_cmd_t cmd;
  crmr_pkg::dp_stat_t  stat;

  crmr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  crmr_dp #(
    .READER_SLOTS (READER_SLOTS),
    .SENDER_SLOTS (SENDER_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Block did not go busy after accepting an item.");

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("Result strobed without an item in progress.");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid)
    else $error("Result strobed right after the final result of an item.");

  a_not_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> busy)
    else $error("Block went idle before the final result of an item.");

endmodule
